// ===== hdl/bfc_pkg.sv =====
// Shared types, constants and codes for the box frustum cull test block.
`default_nettype none
package bfc_pkg;
  localparam int MaxPlanes = 8;
  localparam int PlaneIdxW = 3;

  localparam logic [1:0] MODE_PLANE  = 2'd0;
  localparam logic [1:0] MODE_MATRIX = 2'd1;
  localparam logic [1:0] MODE_TEST   = 2'd2;

  localparam logic CFG_PLANE_COUNT   = 1'b0;
  localparam logic CFG_USE_TRANSFORM = 1'b1;

  // Shared multiply-accumulate unit operations.
  localparam logic [1:0] MAC_CLEAR = 2'd0;
  localparam logic [1:0] MAC_ACC   = 2'd1;
  localparam logic [1:0] MAC_HOLD  = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mac_ctl_t;

  typedef logic signed [31:0] q16_t;
endpackage
`default_nettype wire

// ===== hdl/box_frustum_cull_test.sv =====
// Top level of the box frustum cull test: storage, sequencer and result register.
//
// Channel | Direction | Contents
// in_     | slave     | mode, slot, coef_0..3, box corners
// out_    | master    | visible, cull_plane, hint_now
// cfg_    | write     | plane_count (0), use_transform (1)
//
// Loads are written from the idle state. A box test runs through the planes plain, or with
// transform, until all planes pass or the first culling plane (early exit). Each product
// passes one shared 32x32 multiplier.
// Reset is synchronous, active low; the model matrix returns to identity and the hint to 0.
// The result waits in an output register; a stalled output blocks the next test only.
`default_nettype none
module box_frustum_cull_test
  import bfc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // mode[1:0], slot[4:2], coef_0..coef_3 [132:5], low_x,y,z, high_x,y,z [324:133], pad
  input  wire logic [327:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // visible[0], cull_plane[3:1], hint_now[6:4], pad[7]
  output logic [7:0]        out_tdata,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [3:0]   cfg_wdata
);
  localparam logic [2:0] ST_IDLE = 3'd0, ST_PLANE = 3'd1, ST_XF = 3'd2,
                         ST_XFW = 3'd3, ST_DOT = 3'd4, ST_DOTW = 3'd5, ST_DONE = 3'd6;

  logic [2:0]  state_r;
  logic [3:0]  plane_count_r;
  logic        use_xf_r, xf_r;
  logic [2:0]  hint_r, hsel_r, idx_r, cur_r;
  logic [3:0]  n_r;
  logic        hint_phase_r;
  logic [127:0] plane_r [MaxPlanes];
  logic [127:0] mat_r [4];
  q16_t        low_r [3], high_r [3];
  q16_t        p_r [4];
  logic [2:0]  col_r;
  logic [2:0]  step_r;
  logic        out_valid_r, vis_r;
  logic [2:0]  cull_r, hout_r;
  mac_ctl_t    ctl;
  logic signed [81:0] acc;

  bfc_mac u_mac (.clk(clk), .ctl(ctl), .acc(acc));

  logic [1:0]  in_mode;
  logic [2:0]  in_slot;
  assign in_mode = in_tdata[1:0];
  assign in_slot = in_tdata[4:2];
  assign in_tready = (state_r == ST_IDLE) && !(out_valid_r && in_mode == MODE_TEST);

  function automatic q16_t cf(input logic [127:0] r, input logic [1:0] k);
    return r[32*k +: 32];
  endfunction

  // Floor of a Q32.32 sum to Q16.16, saturated.
  function automatic q16_t sat16(input logic signed [81:0] v);
    logic signed [65:0] s;
    s = v[81:16];
    if (s > 66'sd2147483647) return 32'sh7fffffff;
    if (s < -66'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  always_comb begin
    ctl.op = MAC_HOLD;
    ctl.a  = '0;
    ctl.b  = '0;
    if (state_r == ST_PLANE) ctl.op = MAC_CLEAR;
    if (state_r == ST_XF) begin
      ctl.op = (step_r == 3'd0) ? MAC_CLEAR : MAC_ACC;
      if (step_r != 3'd0) begin
        ctl.a = cf(mat_r[step_r[1:0] - 2'd1], col_r[1:0]);
        ctl.b = cf(plane_r[cur_r], step_r[1:0] - 2'd1);
      end
    end
    if (state_r == ST_DOT) begin
      ctl.op = (step_r == 3'd0) ? MAC_CLEAR : MAC_ACC;
      case (step_r)
        3'd1, 3'd2, 3'd3: begin
          ctl.a = p_r[step_r[1:0] - 2'd1];
          ctl.b = (p_r[step_r[1:0] - 2'd1] > 0) ? high_r[step_r[1:0] - 2'd1]
                                                 : low_r[step_r[1:0] - 2'd1];
        end
        3'd4: begin
          ctl.a = p_r[3];
          ctl.b = 32'sh00010000;
        end
        default: ;
      endcase
    end
  end

  logic [3:0] n_eff;
  assign n_eff = (plane_count_r > 4'(MaxPlanes)) ? 4'(MaxPlanes) : plane_count_r;

  // Next plane in order, skipping the hint plane in transform mode.
  logic [3:0] nxt_idx;
  always_comb begin
    nxt_idx = {1'b0, idx_r} + 4'd1;
    if (xf_r && nxt_idx[2:0] == hsel_r && nxt_idx < n_r) nxt_idx = nxt_idx + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; plane_count_r <= 4'd6; use_xf_r <= 1'b0;
      hint_r <= '0; out_valid_r <= 1'b0;
      mat_r[0] <= {32'd0, 32'd0, 32'd0, 32'h10000};
      mat_r[1] <= {32'd0, 32'd0, 32'h10000, 32'd0};
      mat_r[2] <= {32'd0, 32'h10000, 32'd0, 32'd0};
      mat_r[3] <= {32'h10000, 32'd0, 32'd0, 32'd0};
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PLANE_COUNT) plane_count_r <= cfg_wdata;
        else use_xf_r <= cfg_wdata[0];
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_tvalid && in_tready) begin
          if (in_mode == MODE_PLANE) plane_r[in_slot] <= in_tdata[132:5];
          if (in_mode == MODE_MATRIX && in_slot < 3'd4) mat_r[in_slot[1:0]] <= in_tdata[132:5];
          if (in_mode == MODE_TEST) begin
            for (int k = 0; k < 3; k++) begin
              low_r[k]  <= in_tdata[133 + 32*k +: 32];
              high_r[k] <= in_tdata[229 + 32*k +: 32];
            end
            n_r <= n_eff; xf_r <= use_xf_r; state_r <= ST_PLANE;
          end
        end
        ST_PLANE: begin
          if (n_r == 4'd0) begin
            vis_r <= 1'b1; cull_r <= '0; hout_r <= hint_r; state_r <= ST_DONE;
          end else if (xf_r) begin
            hsel_r <= ({1'b0, hint_r} < n_r) ? hint_r : 3'd0;
            hint_r <= ({1'b0, hint_r} < n_r) ? hint_r : 3'd0;
            cur_r <= ({1'b0, hint_r} < n_r) ? hint_r : 3'd0;
            hint_phase_r <= 1'b1; idx_r <= 3'd7;
            if (({1'b0, hint_r} < n_r ? hint_r : 3'd0) == 3'd0 && n_r > 4'd1)
              idx_r <= 3'd0;
            col_r <= '0; step_r <= '0; state_r <= ST_XF;
          end else begin
            hsel_r <= hint_r; cur_r <= 3'd0; idx_r <= 3'd0; hint_phase_r <= 1'b0;
            p_r[0] <= cf(plane_r[0], 2'd0); p_r[1] <= cf(plane_r[0], 2'd1);
            p_r[2] <= cf(plane_r[0], 2'd2); p_r[3] <= cf(plane_r[0], 2'd3);
            step_r <= '0; state_r <= ST_DOT;
          end
        end
        ST_XF: begin
          if (step_r == 3'd4) state_r <= ST_XFW;
          step_r <= step_r + 3'd1;
        end
        ST_XFW: begin
          if (step_r == 3'd6) begin
            p_r[col_r[1:0]] <= sat16(acc);
            step_r <= '0;
            if (col_r == 3'd3) state_r <= ST_DOT;
            else begin
              col_r <= col_r + 3'd1; state_r <= ST_XF;
            end
          end else step_r <= step_r + 3'd1;
        end
        ST_DOT: begin
          if (step_r == 3'd5) state_r <= ST_DOTW;
          step_r <= step_r + 3'd1;
        end
        ST_DOTW: begin
          step_r <= '0; col_r <= '0;
          if (acc < 0) begin
            vis_r <= 1'b0; cull_r <= cur_r; state_r <= ST_DONE;
            hout_r <= xf_r ? cur_r : hint_r;
            if (xf_r) hint_r <= cur_r;
          end else begin
            logic [3:0] ni;
            ni = hint_phase_r ? ((hsel_r == 3'd0) ? 4'd1 : 4'd0) : nxt_idx;
            if (!hint_phase_r && !xf_r) ni = {1'b0, idx_r} + 4'd1;
            if (ni >= n_r) begin
              vis_r <= 1'b1; cull_r <= '0; hout_r <= hint_r; state_r <= ST_DONE;
            end else begin
              hint_phase_r <= 1'b0; idx_r <= ni[2:0]; cur_r <= ni[2:0];
              if (xf_r) state_r <= ST_XF;
              else begin
                p_r[0] <= cf(plane_r[ni[2:0]], 2'd0); p_r[1] <= cf(plane_r[ni[2:0]], 2'd1);
                p_r[2] <= cf(plane_r[ni[2:0]], 2'd2); p_r[3] <= cf(plane_r[ni[2:0]], 2'd3);
                state_r <= ST_DOT;
              end
            end
          end
        end
        ST_DONE: if (!out_valid_r) begin
          out_valid_r <= 1'b1; state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, hout_r, cull_r, vis_r};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_tready) else $error("ready while busy");
  a_cull: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[3:1] == 3'd0) else $error("visible with culler");
endmodule
`default_nettype wire

// ===== hdl/bfc_mac.sv =====
// Shared exact multiply-accumulate unit with a registered product stage.
`default_nettype none
module bfc_mac
  import bfc_pkg::*;
(
  input  wire logic               clk,
  input  wire mac_ctl_t           ctl,
  output logic signed [81:0]      acc
);
  logic signed [63:0] prod_r;
  logic [1:0]         op_r;
  logic signed [81:0] acc_r;

  always_ff @(posedge clk) begin
    prod_r <= ctl.a * ctl.b;
    op_r   <= ctl.op;
    case (op_r)
      MAC_CLEAR: acc_r <= '0;
      MAC_ACC:   acc_r <= acc_r + 82'(prod_r);
      default:   acc_r <= acc_r;
    endcase
  end

  assign acc = acc_r;
endmodule
`default_nettype wire
